FILE: rtl/core/ctmc_pkg.sv
// Package for the collective trim mode controller.
// Holds the beat payload types, substate encodings and register indexes.
// No dependencies.
package ctmc_pkg;

   localparam int POS_W  = 12;   // position fields on the ports
   localparam int LOAD_W = 24;   // load sample and thresholds
   localparam int STEP_W = 8;    // trim step register
   localparam int CSR_IDX_W = 2;

   localparam int REF_RESET = 500;
   localparam logic [LOAD_W-1:0] OVR_TH_RESET  = 24'd150;
   localparam logic [LOAD_W-1:0] RET_TH_RESET  = 24'd40;
   localparam logic [STEP_W-1:0] TRIM_STEP_RESET = 8'd5;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_OVERRIDE_TH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN_TH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_STEP   = 2'd2;

   typedef enum logic [4:0] {
      SUB_DEFAULT   = 5'b00001,
      SUB_BEEP_UP   = 5'b00010,
      SUB_BEEP_DOWN = 5'b00100,
      SUB_TRIM_HELD = 5'b01000,
      SUB_OVERRIDE  = 5'b10000
   } manual_sub_type;

   typedef enum logic [1:0] {
      AUTO_ACTING   = 2'b01,
      AUTO_OVERRIDE = 2'b10
   } auto_sub_type;

   typedef struct packed {
      logic                     beep_up;
      logic                     beep_down;
      logic                     trim_button;
      logic                     limit_top;
      logic                     limit_bottom;
      logic signed [LOAD_W-1:0] load_sample;
      logic                     autopilot_request;
      logic                     hydraulic_fault;
      logic [POS_W-1:0]         position_command;
      logic [POS_W-1:0]         position_measured;
   } req_type;

   typedef struct packed {
      logic                     motor_enable;
      logic                     motor_up;
      logic                     motor_step;
      logic                     report_beep_up;
      logic                     report_beep_down;
      logic                     report_trim_button;
      logic                     report_override;
      logic signed [LOAD_W-1:0] report_load;
      logic                     mode_autopilot;
   } rsp_type;

   typedef struct packed {
      logic [LOAD_W-1:0] override_threshold;
      logic [LOAD_W-1:0] return_threshold;
      logic [STEP_W-1:0] trim_step;
   } cfg_type;

endpackage

FILE: rtl/core/ctmc_in_reg.sv
// Input register for control tick beats.
// Depends on ctmc_pkg for the request payload type.
module ctmc_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ctmc_pkg::req_type req_data,
   input  logic              take,
   output logic              hold_valid,
   output ctmc_pkg::req_type hold_data
);
   import ctmc_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;

   // accept when empty or when the held beat moves on this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

FILE: rtl/core/ctmc_out_reg.sv
// Result register for the rsp channel.
// Depends on ctmc_pkg for the result payload type.
module ctmc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ctmc_pkg::rsp_type load_data,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ctmc_pkg::rsp_type rsp_data
);
   import ctmc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/core/ctmc_mode_core.sv
// Mode and substate logic, trim reference and spring flag.
// Depends on ctmc_pkg for payload, config and substate types.
module ctmc_mode_core #(
   parameter int MAX_POSITION = 4095
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ctmc_pkg::req_type tick,
   input  ctmc_pkg::cfg_type cfg,
   output ctmc_pkg::rsp_type result
);
   import ctmc_pkg::*;

   localparam int RW = $clog2(MAX_POSITION + 1);
   localparam int SW = ((RW > POS_W) ? RW : POS_W) + 2;
   localparam logic signed [SW-1:0] MaxPosS = SW'(MAX_POSITION);
   localparam logic [RW-1:0] RefResetV =
      (REF_RESET > MAX_POSITION) ? RW'(MAX_POSITION) : RW'(REF_RESET);

   logic           mode_ff, mode_in;       // 1 autopilot
   manual_sub_type man_ff, man_in;
   auto_sub_type   aut_ff, aut_in;
   logic [RW-1:0]  trim_ref_ff, trim_ref_in;
   logic           spring_ff, spring_in;

   logic [LOAD_W-1:0]  mag;
   logic               above, below;
   logic signed [SW-1:0] ref_s, meas_s, cmd_s, step_s, new_ref_s;

   function automatic logic [RW-1:0] clamp_ref(input logic signed [SW-1:0] v);
      logic [RW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > MaxPosS) begin
         r = RW'(MAX_POSITION);
      end else begin
         r = v[RW-1:0];
      end
      return r;
   endfunction

   // |load| fits 24 bits unsigned, most negative sample included
   assign mag   = tick.load_sample[LOAD_W-1] ? $unsigned(-tick.load_sample)
                                             : $unsigned(tick.load_sample);
   assign above = mag > cfg.override_threshold;
   assign below = mag < cfg.return_threshold;

   assign ref_s  = $signed(SW'(trim_ref_ff));
   assign meas_s = $signed(SW'(tick.position_measured));
   assign cmd_s  = $signed(SW'(tick.position_command));
   assign step_s = $signed(SW'(cfg.trim_step));

   always_comb begin
      logic en, up, stp, track;
      en = 1'b0;
      up = 1'b1;
      stp = 1'b0;
      track = 1'b0;
      mode_in = mode_ff;
      man_in = man_ff;
      aut_in = aut_ff;
      trim_ref_in = trim_ref_ff;
      spring_in = spring_ff;
      new_ref_s = '0;
      result = '0;

      if (tick.hydraulic_fault) begin
         // lock motor, keep modes and reference
         spring_in = 1'b0;
         result.motor_enable = 1'b1;
         result.motor_up = 1'b1;
         result.report_override = 1'b1;
         result.mode_autopilot = mode_ff;
      end else begin
         if (!mode_ff && tick.autopilot_request) begin
            mode_in = 1'b1;
            aut_in = AUTO_ACTING;
         end else if (mode_ff && !tick.autopilot_request) begin
            mode_in = 1'b0;
            man_in = SUB_DEFAULT;
            spring_in = 1'b1;
         end

         if (!mode_in) begin
            case (man_in)
               SUB_DEFAULT: begin
                  spring_in = 1'b1;
                  if (tick.trim_button) begin
                     man_in = SUB_TRIM_HELD;
                  end else if (tick.beep_up) begin
                     man_in = SUB_BEEP_UP;
                  end else if (tick.beep_down) begin
                     man_in = SUB_BEEP_DOWN;
                  end else if (above) begin
                     man_in = SUB_OVERRIDE;
                  end
                  track = 1'b1;
               end
               SUB_TRIM_HELD: begin
                  spring_in = 1'b0;
                  if (!tick.trim_button) begin
                     trim_ref_in = clamp_ref(meas_s);
                     man_in = SUB_DEFAULT;
                  end
               end
               SUB_BEEP_UP: begin
                  if (tick.limit_top || !tick.beep_up) begin
                     man_in = SUB_DEFAULT;
                  end else begin
                     trim_ref_in = clamp_ref(ref_s + step_s);
                     en = 1'b1;
                     up = 1'b1;
                     stp = 1'b1;
                  end
               end
               SUB_BEEP_DOWN: begin
                  if (tick.limit_bottom || !tick.beep_down) begin
                     man_in = SUB_DEFAULT;
                  end else begin
                     trim_ref_in = clamp_ref(ref_s - step_s);
                     en = 1'b1;
                     up = 1'b0;
                     stp = 1'b1;
                  end
               end
               default: begin
                  // override: hold until the load falls below return level
                  spring_in = 1'b1;
                  if (below) begin
                     man_in = SUB_DEFAULT;
                  end
                  track = 1'b1;
               end
            endcase
         end else begin
            spring_in = 1'b1;
            track = 1'b1;
            if (aut_in == AUTO_ACTING) begin
               trim_ref_in = clamp_ref(cmd_s);
               if (above) begin
                  aut_in = AUTO_OVERRIDE;
               end
            end else if (below) begin
               aut_in = AUTO_ACTING;
            end
         end

         // step toward the updated reference
         new_ref_s = $signed(SW'(trim_ref_in));
         if (track && (meas_s != new_ref_s)) begin
            en = 1'b1;
            up = new_ref_s > meas_s;
            stp = 1'b1;
         end

         result.motor_enable = en;
         result.motor_up = up;
         result.motor_step = stp;
         result.report_beep_up = tick.beep_up;
         result.report_beep_down = tick.beep_down;
         result.report_trim_button = tick.trim_button;
         result.report_override = (man_in == SUB_OVERRIDE) || (aut_in == AUTO_OVERRIDE);
         result.report_load = spring_in ? tick.load_sample : '0;
         result.mode_autopilot = mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         man_ff <= SUB_DEFAULT;
         aut_ff <= AUTO_ACTING;
         trim_ref_ff <= RefResetV;
         spring_ff <= 1'b1;
      end else if (advance) begin
         mode_ff <= mode_in;
         man_ff <= man_in;
         aut_ff <= aut_in;
         trim_ref_ff <= trim_ref_in;
         spring_ff <= spring_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      32'(trim_ref_ff) <= MAX_POSITION)
      else $error("trim reference beyond travel");

   assert property (@(posedge clock) disable iff (reset)
      advance && tick.hydraulic_fault |=>
         $stable(mode_ff) && $stable(man_ff) && $stable(aut_ff) &&
         $stable(trim_ref_ff) && !spring_ff)
      else $error("fault beat changed mode state");

   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(trim_ref_ff) && $stable(mode_ff))
      else $error("state moved without a beat");

endmodule

FILE: rtl/core/collective_trim_mode_controller_unit.sv
// Top level of the collective trim mode controller.
// Depends on ctmc_pkg, ctmc_in_reg, ctmc_mode_core and ctmc_out_reg.
//
// Each req beat is one control tick: button and limit levels, a signed load
// sample, autopilot and fault requests, commanded and measured positions.
// Each tick yields exactly one rsp beat with the stepper enable, direction
// and step pulse plus telemetry. The block holds manual/autopilot mode with
// substates (default, trim held, beep up, beep down, override; acting or
// override), a trim reference saturated to 0..MAX_POSITION and a spring
// flag. Override entry and exit use a hysteresis pair of thresholds on the
// load magnitude. A hydraulic fault locks the motor and reports override.
// Rate: one tick per clock cycle sustained while the receiver takes rsp beats.
// An accepted req beat sits in the input register, then the mode logic runs
// in a single pass and loads the result register. The input register
// accepts a new beat whenever its held beat moves on, so a waiting result
// does not stall intake until both stages are full.
// Configuration: csr writes are always accepted; write only while idle.
// Index 0 override threshold, 1 return threshold, 2 trim step; other
// indexes are ignored. No clearing pass after reset.
module collective_trim_mode_controller_unit #(
   parameter int MAX_POSITION = 4095
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ctmc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ctmc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ctmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ctmc_pkg::LOAD_W-1:0]       csr_data
);
   import ctmc_pkg::*;

   logic    hold_valid;
   req_type hold_data;
   logic    can_load;
   logic    advance;
   rsp_type core_result;
   cfg_type cfg_ff;

   // config port never stalls
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.override_threshold <= OVR_TH_RESET;
         cfg_ff.return_threshold <= RET_TH_RESET;
         cfg_ff.trim_step <= TRIM_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OVERRIDE_TH: cfg_ff.override_threshold <= csr_data;
            CSR_RETURN_TH:   cfg_ff.return_threshold <= csr_data;
            CSR_TRIM_STEP:   cfg_ff.trim_step <= csr_data[STEP_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   ctmc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   // advance the held tick when the result register has room
   assign advance = hold_valid && can_load;

   ctmc_mode_core #(
      .MAX_POSITION (MAX_POSITION)
   ) u_mode_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tick    (hold_data),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   ctmc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (core_result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motor_step |-> rsp_data.motor_enable)
      else $error("step pulse without enable");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.motor_step |-> rsp_data.motor_up)
      else $error("idle direction not up");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> hold_valid && rsp_valid && !rsp_ready)
      else $error("intake stalled with room in the pipe");

endmodule

FILE: tb/tb_collective_trim_mode_controller_unit.sv
// Self-checking testbench for collective_trim_mode_controller_unit.
// Predicts every rsp beat from a behavioral copy of the mode logic and compares field by field.
// Depends on ctmc_pkg and the RTL of the controller.
module tb_collective_trim_mode_controller_unit;
   import ctmc_pkg::*;

   localparam int MAX_POS     = 4095;
   localparam int HOLD_CYCLES = 300;      // long receiver hold-off under pressure
   localparam int CYCLE_LIMIT = 100000;
   localparam logic [CSR_IDX_W-1:0] SPARE_INDEX = 2'd3;   // unmapped register index

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LOAD_W-1:0]    csr_data = '0;

   // predicted controller state and register copies
   int             override_th = 150;
   int             return_th   = 40;
   int             step_size   = 5;
   bit             ap_mode     = 1'b0;
   manual_sub_type manual_sub  = SUB_DEFAULT;
   auto_sub_type   ap_sub      = AUTO_ACTING;
   int             trim_ref    = REF_RESET;
   bit             spring_on   = 1'b1;

   rsp_type pending_outputs[$];
   req_type walk_state = '0;
   int      mismatch_count = 0;
   int      cycle_count = 0;
   bit      gaps_off = 1'b0;
   int      hold_requests = 0;
   int      hold_seen = 0;
   int      hold_left = 0;

   collective_trim_mode_controller_unit #(.MAX_POSITION(MAX_POS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("collective_trim_mode_controller_unit: mismatch");
      $finish;
   end

   function automatic int clamp_position(input int v);
      if (v < 0) return 0;
      if (v > MAX_POS) return MAX_POS;
      return v;
   endfunction

   // Advance the predicted state by one control tick and return the stepper
   // command and telemetry that the tick must produce.
   function automatic rsp_type predict_stepper_output(input req_type t);
      rsp_type r;
      int      load_v;
      int      mag;
      int      meas;
      bit      above;
      bit      below;
      bit      track;
      load_v = $signed(t.load_sample);
      mag    = (load_v < 0) ? -load_v : load_v;
      above  = mag > override_th;
      below  = mag < return_th;
      meas   = int'(t.position_measured);
      track  = 1'b0;
      r = '0;
      r.motor_up = 1'b1;

      // Fault locks the motor; modes, substates and reference hold.
      if (t.hydraulic_fault) begin
         spring_on = 1'b0;
         r.motor_enable    = 1'b1;
         r.report_override = 1'b1;
         r.mode_autopilot  = ap_mode;
         return r;
      end

      if (!ap_mode && t.autopilot_request) begin
         ap_mode = 1'b1;
         ap_sub  = AUTO_ACTING;
      end else if (ap_mode && !t.autopilot_request) begin
         ap_mode    = 1'b0;
         manual_sub = SUB_DEFAULT;
         spring_on  = 1'b1;
      end

      if (!ap_mode) begin
         case (manual_sub)
            SUB_DEFAULT: begin
               spring_on = 1'b1;
               if (t.trim_button) manual_sub = SUB_TRIM_HELD;
               else if (t.beep_up) manual_sub = SUB_BEEP_UP;
               else if (t.beep_down) manual_sub = SUB_BEEP_DOWN;
               else if (above) manual_sub = SUB_OVERRIDE;
               track = 1'b1;
            end
            SUB_TRIM_HELD: begin
               spring_on = 1'b0;
               if (!t.trim_button) begin
                  trim_ref   = clamp_position(meas);
                  manual_sub = SUB_DEFAULT;
               end
            end
            SUB_BEEP_UP: begin
               if (t.limit_top || !t.beep_up) begin
                  manual_sub = SUB_DEFAULT;
               end else begin
                  trim_ref = clamp_position(trim_ref + step_size);
                  r.motor_enable = 1'b1;
                  r.motor_step   = 1'b1;
               end
            end
            SUB_BEEP_DOWN: begin
               if (t.limit_bottom || !t.beep_down) begin
                  manual_sub = SUB_DEFAULT;
               end else begin
                  trim_ref = clamp_position(trim_ref - step_size);
                  r.motor_enable = 1'b1;
                  r.motor_up     = 1'b0;
                  r.motor_step   = 1'b1;
               end
            end
            default: begin
               spring_on = 1'b1;
               if (below) manual_sub = SUB_DEFAULT;
               track = 1'b1;
            end
         endcase
      end else if (ap_sub == AUTO_ACTING) begin
         trim_ref  = clamp_position(int'(t.position_command));
         spring_on = 1'b1;
         track     = 1'b1;
         if (above) ap_sub = AUTO_OVERRIDE;
      end else begin
         spring_on = 1'b1;
         track     = 1'b1;
         if (below) ap_sub = AUTO_ACTING;
      end

      // Track: step toward the reference when off it.
      if (track && meas != trim_ref) begin
         r.motor_enable = 1'b1;
         r.motor_up     = trim_ref > meas;
         r.motor_step   = 1'b1;
      end

      r.report_beep_up     = t.beep_up;
      r.report_beep_down   = t.beep_down;
      r.report_trim_button = t.trim_button;
      // an override substate is reported even while the other mode runs
      r.report_override = (manual_sub == SUB_OVERRIDE) || (ap_sub == AUTO_OVERRIDE);
      r.report_load     = spring_on ? t.load_sample : '0;
      r.mode_autopilot  = ap_mode;
      return r;
   endfunction

   // Quiet tick: no buttons, no load, sitting at the given position.
   function automatic req_type idle_tick(input int meas);
      req_type t;
      t = '0;
      t.position_measured = meas[POS_W-1:0];
      return t;
   endfunction

   // Random walk over ticks: buttons and modes are held for stretches so the
   // substates are actually reached; a tenth of the ticks are pure noise.
   function automatic req_type next_walk_tick();
      req_type     t;
      logic [63:0] bits;
      int          mag;
      int          meas;
      int          load_v;
      if ($urandom_range(99) < 10) begin
         bits = {$urandom, $urandom};
         t = bits[$bits(req_type)-1:0];
         walk_state = t;
         return t;
      end
      t = walk_state;
      if ($urandom_range(99) < 12) t.beep_up = ~t.beep_up;
      if ($urandom_range(99) < 12) t.beep_down = ~t.beep_down;
      if ($urandom_range(99) < 8) t.trim_button = ~t.trim_button;
      if ($urandom_range(99) < 4) t.autopilot_request = ~t.autopilot_request;
      t.limit_top       = $urandom_range(99) < 8;
      t.limit_bottom    = $urandom_range(99) < 8;
      t.hydraulic_fault = $urandom_range(99) < 3;
      if ($urandom_range(99) < 30) t.position_command = POS_W'($urandom);

      case ($urandom_range(9))
         0, 1, 2: meas = trim_ref;
         3, 4, 5: meas = clamp_position(trim_ref + int'($urandom_range(6)) - 3);
         default: meas = int'($urandom_range(MAX_POS));
      endcase
      t.position_measured = meas[POS_W-1:0];

      // Aim four of ten loads at the hysteresis edges and two more near the band.
      case ($urandom_range(9))
         0: mag = override_th;
         1: mag = override_th + 1;
         2: mag = return_th;
         3: mag = return_th - 1;
         4, 5: mag = int'($urandom_range(override_th + override_th / 4 + 2));
         6: mag = 8388608;
         default: mag = int'($urandom_range(8388608));
      endcase
      if (mag < 0) mag = 0;
      if (mag > 8388608) mag = 8388608;
      load_v = (mag == 8388608 || $urandom_range(1)) ? -mag : mag;
      t.load_sample = load_v[LOAD_W-1:0];
      walk_state = t;
      return t;
   endfunction

   // Offer one tick, hold it until the beat moves, then predict its result.
   task automatic send_tick(input req_type t);
      while (!gaps_off && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      pending_outputs.insert(pending_outputs.size(), predict_stepper_output(t));
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LOAD_W-1:0] value,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_OVERRIDE_TH: override_th = int'(value);
         CSR_RETURN_TH:   return_th   = int'(value);
         CSR_TRIM_STEP:   step_size   = int'(value[STEP_W-1:0]);
         default: ;
      endcase
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [LOAD_W-1:0] ovr, input logic [LOAD_W-1:0] ret,
                            input logic [LOAD_W-1:0] stp);
      write_reg(CSR_OVERRIDE_TH, ovr, 1'b0);
      write_reg(CSR_RETURN_TH, ret, 1'b0);
      write_reg(CSR_TRIM_STEP, stp, 1'b1);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // Receiver: random stalls, a quiet stretch, and a long hold-off on request.
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= gaps_off || ($urandom_range(99) >= 7);
      end
   end

   // Compare each rsp beat with the oldest prediction.
   always @(posedge clock) begin : check_outputs
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected rsp beat, expected none, actual %h", $time, rsp_data);
         end else begin
            want = pending_outputs.pop_front();
            check_field("motor_enable", want.motor_enable, rsp_data.motor_enable);
            check_field("motor_up", want.motor_up, rsp_data.motor_up);
            check_field("motor_step", want.motor_step, rsp_data.motor_step);
            check_field("report_beep_up", want.report_beep_up, rsp_data.report_beep_up);
            check_field("report_beep_down", want.report_beep_down, rsp_data.report_beep_down);
            check_field("report_trim_button", want.report_trim_button,
                        rsp_data.report_trim_button);
            check_field("report_override", want.report_override, rsp_data.report_override);
            check_field("report_load", want.report_load, rsp_data.report_load);
            check_field("mode_autopilot", want.mode_autopilot, rsp_data.mode_autopilot);
         end
      end
   end

   // Walk through every substate, both override exits and the fault lock.
   task automatic test_mode_walk();
      req_type t;
      t = idle_tick(500);
      send_tick(t);                                  // on reference: motor off
      t = idle_tick(0);
      t.load_sample = 24'h800000;                    // most negative load enters override
      send_tick(t);
      t = idle_tick(4095);
      t.load_sample = 24'd100;                       // inside the hysteresis band: hold
      send_tick(t);
      t = idle_tick(500);
      t.load_sample = 24'd39;                        // just below return: back to default
      send_tick(t);
      t = idle_tick(500);
      t.beep_up = 1'b1;
      send_tick(t);
      send_tick(t);                                  // step reference up
      t.limit_top = 1'b1;                            // top limit ends beep without a step
      send_tick(t);
      t = idle_tick(505);
      t.beep_down = 1'b1;
      send_tick(t);
      send_tick(t);
      t.limit_bottom = 1'b1;
      send_tick(t);
      t = idle_tick(123);
      t.trim_button = 1'b1;
      t.load_sample  = 24'h7FFFFF;
      send_tick(t);
      send_tick(t);                                  // trim held: spring off, load hidden
      t.trim_button = 1'b0;
      t.position_measured = 12'd4095;                // release copies measured position
      send_tick(t);
      t = idle_tick(4095);
      t.autopilot_request = 1'b1;
      send_tick(t);                                  // autopilot acting, command 0
      t.load_sample = 24'd151;
      send_tick(t);                                  // autopilot override
      t.load_sample = 24'd40;
      t.position_command = 12'd4095;
      send_tick(t);                                  // not below return: stay
      t.hydraulic_fault = 1'b1;
      t.beep_up = 1'b1;
      send_tick(t);                                  // fault lock in autopilot
      t = idle_tick(0);
      send_tick(t);                                  // back to manual, auto override still shown
      t.autopilot_request = 1'b1;
      send_tick(t);                                  // re-entry clears auto override
      t = idle_tick(0);
      t.hydraulic_fault = 1'b1;
      t.trim_button = 1'b1;
      send_tick(t);                                  // fault lock in manual
   endtask

   // Register extremes: saturate the reference both ways, ignore the spare index,
   // then run ticks with thresholds at zero and at full scale.
   task automatic test_register_extremes();
      req_type t;
      wait_idle();
      write_reg(SPARE_INDEX, 24'h5A5A5A, 1'b0);      // spare index: no effect
      write_reg(CSR_TRIM_STEP, 24'hA5A5FF, 1'b1);    // upper bits dropped
      t = idle_tick(0);
      t.beep_up = 1'b1;
      repeat (18) send_tick(t);
      t.beep_up = 1'b0;
      t.beep_down = 1'b1;
      repeat (20) send_tick(t);
      wait_idle();
      configure(24'd0, 24'd0, 24'd0);
      repeat (30) send_tick(next_walk_tick());
      wait_idle();
      configure(24'h800000, 24'h800000, 24'd255);
      repeat (30) send_tick(next_walk_tick());
      wait_idle();
      configure(24'hFFFFFF, 24'hFFFFFF, 24'd1);
      repeat (30) send_tick(next_walk_tick());
   endtask

   // Full rate on both sides, no gaps anywhere.
   task automatic test_back_to_back();
      wait_idle();
      configure(OVR_TH_RESET, RET_TH_RESET, 24'(TRIM_STEP_RESET));
      gaps_off = 1'b1;
      repeat (200) send_tick(next_walk_tick());
      gaps_off = 1'b0;
   endtask

   // Hold the receiver off while ticks keep coming so the pipe fills and stalls.
   task automatic test_output_backpressure();
      hold_requests++;
      repeat (60) send_tick(next_walk_tick());
   endtask

   task automatic test_random_ticks();
      int ovr;
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: configure(OVR_TH_RESET, RET_TH_RESET, 24'(TRIM_STEP_RESET));
            1: begin
               ovr = int'($urandom_range(3000));
               configure(24'(ovr), 24'($urandom_range(ovr)), 24'($urandom_range(255)));
            end
            2: configure(24'($urandom_range(300)), 24'($urandom_range(600)),
                         24'($urandom_range(16, 1)));
            3: configure(24'($urandom), 24'($urandom), 24'($urandom));
            4: configure(24'h800000, 24'($urandom_range(8388608)), 24'd255);
            default: configure(24'd1, 24'd1, 24'd1);
         endcase
         repeat (175) send_tick(next_walk_tick());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_mode_walk();
      test_register_extremes();
      test_back_to_back();
      test_output_backpressure();
      test_random_ticks();
      wait_idle();
      // let any stray beat show up before the verdict
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_outputs.size() == 0)
         $display("collective_trim_mode_controller_unit: match");
      else
         $display("collective_trim_mode_controller_unit: mismatch");
      $finish;
   end

endmodule
